// ===== src/vra_pkg.sv =====
// Shared types and constants for the virtual region allocator.
// No dependencies; compiled before every other file of the block.
package vra_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned PAGE_CNT_W = 21;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned STATUS_W   = 3;
  // Region ends are kept one bit wider so that the top of the address space fits.
  localparam int unsigned END_W      = ADDR_W + 1;

  localparam logic [PAGE_CNT_W-1:0] PAGE_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_CHECK   = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_ZERO_SIZE = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_OVERRUN   = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } status_e;

  // Broadcast to every table cell.
  typedef struct packed {
    logic load;   // write the new entry into the cell at the fill index
    logic shift;  // compaction: cells at or past the hit take their neighbor
  } cell_ctrl_t;

endpackage

// ===== src/vra_req_if.sv =====
// Request channel of the virtual region allocator: valid/ready plus payload.
// Depends on vra_pkg for field widths.
interface vra_req_if;
  logic                            valid;
  logic                            ready;
  logic [vra_pkg::KIND_W-1:0]      kind;
  logic [vra_pkg::ADDR_W-1:0]      request_bytes;
  logic [vra_pkg::ADDR_W-1:0]      address;

  modport source (output valid, kind, request_bytes, address, input ready);
  modport sink   (input valid, kind, request_bytes, address, output ready);
endinterface

// ===== src/vra_rsp_if.sv =====
// Result channel of the virtual region allocator: valid/ready plus payload.
// Depends on vra_pkg for field widths.
interface vra_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [vra_pkg::STATUS_W-1:0]       status;
  logic [vra_pkg::ADDR_W-1:0]         region_address;
  logic [vra_pkg::PAGE_CNT_W-1:0]     page_count;
  logic                               legitimate;

  modport source (output valid, status, region_address, page_count, legitimate,
                  input ready);
  modport sink   (input valid, status, region_address, page_count, legitimate,
                  output ready);
endinterface

// ===== src/vra_cell.sv =====
// One entry of the region table: base, page count, match flag and the
// compaction path to its neighbor. Depends on vra_pkg.
module vra_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned CNT_W      = 5,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic                              clk_i,
  input  vra_pkg::cell_ctrl_t               ctrl_i,
  input  logic [CNT_W-1:0]                  count_i,
  input  logic [vra_pkg::ADDR_W-1:0]        addr_i,
  input  logic [vra_pkg::ADDR_W-1:0]        new_base_i,
  input  logic [vra_pkg::PAGE_CNT_W-1:0]    new_pages_i,
  input  logic [vra_pkg::ADDR_W-1:0]        nxt_base_i,
  input  logic [vra_pkg::PAGE_CNT_W-1:0]    nxt_pages_i,
  input  logic                              hit_i,
  output logic                              hit_o,
  output logic [vra_pkg::ADDR_W-1:0]        base_o,
  output logic [vra_pkg::PAGE_CNT_W-1:0]    pages_o,
  output logic [vra_pkg::PAGE_CNT_W-1:0]    found_pages_o,
  output logic [vra_pkg::END_W-1:0]         last_end_o
);

  logic [vra_pkg::ADDR_W-1:0]     base_q, base_d;
  logic [vra_pkg::PAGE_CNT_W-1:0] pages_q, pages_d;
  logic                           match_q, match_d;
  logic                           valid;
  logic                           first;
  logic [vra_pkg::END_W-1:0]      end_addr;

  assign valid    = CNT_W'(IDX) < count_i;
  assign match_d  = valid && (base_q == addr_i);
  assign hit_o    = hit_i | match_q;
  assign first    = match_q & ~hit_i;
  assign end_addr = {1'b0, base_q} + (vra_pkg::END_W'(pages_q) << PAGE_SHIFT);

  assign base_o        = base_q;
  assign pages_o       = pages_q;
  assign found_pages_o = first ? pages_q : '0;
  assign last_end_o    = (count_i == CNT_W'(IDX + 1)) ? end_addr : '0;

  always_comb begin
    base_d  = base_q;
    pages_d = pages_q;
    if (ctrl_i.load && (count_i == CNT_W'(IDX))) begin
      base_d  = new_base_i;
      pages_d = new_pages_i;
    end else if (ctrl_i.shift && hit_o) begin
      base_d  = nxt_base_i;
      pages_d = nxt_pages_i;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q  <= base_d;
    pages_q <= pages_d;
    match_q <= match_d;
  end

endmodule

// ===== src/virtual_region_allocator_core.sv =====
// Virtual region allocator: an ordered table of regions in a row of cells.
// Allocate and check go from the request transfer to the result through
// capture, page/base compute, and compare and commit; commit waits while an
// earlier result is still unaccepted. Release also refreshes the table tail
// through the cell row before the next request transfer. A new request is
// taken only once the last one is through. A finished result sits in an
// output register while the next request is taken. Depends on vra_pkg,
// vra_req_if, vra_rsp_if and vra_cell.
module virtual_region_allocator_core #(
  parameter int unsigned MAX_REGIONS = 16,
  parameter int unsigned PAGE_SHIFT  = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [vra_pkg::ADDR_W-1:0]  cfg_wdata_i,
  vra_req_if.sink                     req_i,
  vra_rsp_if.source                   rsp_o
);

  localparam int unsigned CNT_W = $clog2(MAX_REGIONS + 1);
  // Page count register: wide enough for the rounded request and for the result field.
  localparam int unsigned PG_W  = (vra_pkg::END_W - PAGE_SHIFT > vra_pkg::PAGE_CNT_W) ?
                                  vra_pkg::END_W - PAGE_SHIFT : vra_pkg::PAGE_CNT_W;
  localparam int unsigned SUM_W = vra_pkg::END_W + 1;
  localparam logic [vra_pkg::END_W-1:0] PAGE_MASK = vra_pkg::END_W'((1 << PAGE_SHIFT) - 1);
  localparam logic [SUM_W-1:0] ADDR_LIMIT = SUM_W'(1) << vra_pkg::ADDR_W;

  localparam logic CFG_POOL_BASE  = 1'b0;
  localparam logic CFG_POOL_BYTES = 1'b1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CALC   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;
  localparam logic [1:0] ST_TAIL   = 2'd3;

  logic [1:0]                     state_q, state_d;
  logic [vra_pkg::ADDR_W-1:0]     pool_base_q, pool_bytes_q;
  logic [vra_pkg::END_W-1:0]      limit_q;
  logic [CNT_W-1:0]               count_q, count_d;
  logic [vra_pkg::END_W-1:0]      tail_q, tail_d;

  vra_pkg::kind_e                 kind_q;
  logic [vra_pkg::ADDR_W-1:0]     bytes_q, addr_q;
  logic [PG_W-1:0]                pages_q, pages_d;
  logic [vra_pkg::END_W-1:0]      base_q, base_d;

  logic                           out_valid_q, out_valid_d;
  logic [vra_pkg::STATUS_W-1:0]   status_q, status_d;
  logic [vra_pkg::ADDR_W-1:0]     raddr_q, raddr_d;
  logic [vra_pkg::PAGE_CNT_W-1:0] rpages_q, rpages_d;
  logic                           legit_q, legit_d;

  logic                           accept;
  logic                           commit_go;
  logic [SUM_W-1:0]               end_w;
  logic                           overrun;
  logic                           found;
  vra_pkg::cell_ctrl_t            ctrl;

  logic [MAX_REGIONS:0]           hit;
  logic [vra_pkg::ADDR_W-1:0]     cell_base   [MAX_REGIONS];
  logic [vra_pkg::PAGE_CNT_W-1:0] cell_pages  [MAX_REGIONS];
  logic [vra_pkg::PAGE_CNT_W-1:0] cell_fpages [MAX_REGIONS];
  logic [vra_pkg::END_W-1:0]      cell_end    [MAX_REGIONS];
  logic [vra_pkg::PAGE_CNT_W-1:0] found_pages;
  logic [vra_pkg::END_W-1:0]      last_end;

  assign accept    = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign commit_go = (state_q == ST_COMMIT) && (!out_valid_q || rsp_o.ready);

  // ---------------- cell row ----------------
  assign hit[0] = 1'b0;

  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
    logic [vra_pkg::ADDR_W-1:0]     nxt_base;
    logic [vra_pkg::PAGE_CNT_W-1:0] nxt_pages;
    if (i == MAX_REGIONS - 1) begin : g_end
      assign nxt_base  = cell_base[i];
      assign nxt_pages = cell_pages[i];
    end else begin : g_mid
      assign nxt_base  = cell_base[i+1];
      assign nxt_pages = cell_pages[i+1];
    end
    vra_cell #(
      .IDX        (i),
      .CNT_W      (CNT_W),
      .PAGE_SHIFT (PAGE_SHIFT)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .count_i       (count_q),
      .addr_i        (addr_q),
      .new_base_i    (base_q[vra_pkg::ADDR_W-1:0]),
      .new_pages_i   (pages_q[vra_pkg::PAGE_CNT_W-1:0]),
      .nxt_base_i    (nxt_base),
      .nxt_pages_i   (nxt_pages),
      .hit_i         (hit[i]),
      .hit_o         (hit[i+1]),
      .base_o        (cell_base[i]),
      .pages_o       (cell_pages[i]),
      .found_pages_o (cell_fpages[i]),
      .last_end_o    (cell_end[i])
    );
  end

  assign found = hit[MAX_REGIONS];

  // At most one cell drives a nonzero value onto each of these.
  always_comb begin
    found_pages = '0;
    last_end    = '0;
    for (int i = 0; i < MAX_REGIONS; i++) begin
      found_pages = found_pages | cell_fpages[i];
      last_end    = last_end | cell_end[i];
    end
  end

  // ---------------- allocate arithmetic ----------------
  assign end_w   = SUM_W'(base_q) + (SUM_W'(pages_q) << PAGE_SHIFT);
  assign overrun = (SUM_W'(pages_q) > SUM_W'(vra_pkg::PAGE_MAX)) ||
                   (end_w > SUM_W'(limit_q)) || (end_w > ADDR_LIMIT);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    tail_d      = tail_q;
    pages_d     = pages_q;
    base_d      = base_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    status_d    = status_q;
    raddr_d     = raddr_q;
    rpages_d    = rpages_q;
    legit_d     = legit_q;
    ctrl        = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        pages_d = PG_W'(({1'b0, bytes_q} + PAGE_MASK) >> PAGE_SHIFT);
        base_d  = (count_q == '0) ? {1'b0, pool_base_q} : tail_q;
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit_go) begin
          out_valid_d = 1'b1;
          status_d    = vra_pkg::STAT_OK;
          raddr_d     = '0;
          rpages_d    = '0;
          legit_d     = 1'b0;
          state_d     = ST_IDLE;
          unique case (kind_q)
            vra_pkg::KIND_ALLOC: begin
              priority if (bytes_q == '0) begin
                status_d = vra_pkg::STAT_ZERO_SIZE;
              end else if (count_q == CNT_W'(MAX_REGIONS)) begin
                status_d = vra_pkg::STAT_FULL;
              end else if (overrun) begin
                status_d = vra_pkg::STAT_OVERRUN;
              end else begin
                ctrl.load = 1'b1;
                count_d   = count_q + CNT_W'(1);
                tail_d    = end_w[vra_pkg::END_W-1:0];
                raddr_d   = base_q[vra_pkg::ADDR_W-1:0];
                rpages_d  = pages_q[vra_pkg::PAGE_CNT_W-1:0];
              end
            end
            vra_pkg::KIND_RELEASE: begin
              if (found) begin
                ctrl.shift = 1'b1;
                count_d    = count_q - CNT_W'(1);
                raddr_d    = addr_q;
                rpages_d   = found_pages;
                state_d    = ST_TAIL;
              end else begin
                status_d = vra_pkg::STAT_NOT_FOUND;
              end
            end
            vra_pkg::KIND_CHECK: begin
              legit_d = ({1'b0, addr_q} >= {1'b0, pool_base_q}) && ({1'b0, addr_q} < limit_q);
            end
            default: begin
            end
          endcase
        end
      end
      ST_TAIL: begin
        // Table has been compacted; pick up the end of the new last entry.
        tail_d  = last_end;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      pool_base_q  <= '0;
      pool_bytes_q <= '0;
      limit_q      <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      limit_q     <= {1'b0, pool_base_q} + {1'b0, pool_bytes_q};
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_POOL_BASE:  pool_base_q  <= cfg_wdata_i;
          CFG_POOL_BYTES: pool_bytes_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= vra_pkg::kind_e'(req_i.kind);
      bytes_q <= req_i.request_bytes;
      addr_q  <= req_i.address;
    end
    tail_q   <= tail_d;
    pages_q  <= pages_d;
    base_q   <= base_d;
    status_q <= status_d;
    raddr_q  <= raddr_d;
    rpages_q <= rpages_d;
    legit_q  <= legit_d;
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = status_q;
  assign rsp_o.region_address = raddr_q;
  assign rsp_o.page_count     = rpages_q;
  assign rsp_o.legitimate     = legit_q;

  // ---------------- assertions ----------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_REGIONS))
    else $error("region count above table depth");

  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_COMMIT)
    else $error("result raised outside commit");

  a_release_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit_go && kind_q == vra_pkg::KIND_RELEASE && found) |=>
      (count_q == $past(count_q) - CNT_W'(1)) && state_q == ST_TAIL)
    else $error("release did not shrink the table");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !accept)
    else $error("request taken while busy");

endmodule
